// File: design/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 block hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int WORDS_PER_BLOCK = 16;
  localparam int ROUNDS          = 64;
  localparam int DIGEST_WORDS    = 8;
  localparam int QUEUE_DEPTH     = 2;

  // one complete message block handed from front to back
  typedef struct packed {
    logic [WORDS_PER_BLOCK-1:0][31:0] words;  // words[0] is the first word
    logic                             init;   // start from the initial hash
    logic                             last;   // final block of its message
  } sha_blk_t;

  localparam logic [31:0] INIT_HASH [DIGEST_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
    rotr = (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    choose = (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    majority = (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// File: design/sha256_block_hasher.sv
// ----------------------------------------------------------------------------
// sha256_block_hasher
// SHA-256 over pre-padded messages fed one 32-bit big-endian word a request.
// ----------------------------------------------------------------------------
//
//   channel   valid      stall      payload
//   -------   --------   --------   ----------------------------------------
//   message   msg_valid  msg_stall  message_word, first_of_message,
//                                   last_of_message
//   digest    dig_valid  dig_stall  digest_word, word_index, last_word
//
// Cycles: the front takes one word a cycle while msg_stall is low. The back
//   works through each full block as a load, the rounds at one round a cycle
//   and a chaining add, and takes no new block until it is done; the round
//   loop of the compression engine sets the sustained rate.
// A final block adds 8 digest requests, one a cycle when dig_stall is low.
// Reset: synchronous, active high; the chaining value returns to the
//   initial hash and the block queue empties.
// Stalls: msg_stall rises only on a block's sixteenth word while the queue
//   is full; a stalled digest holds the back, and the front once it fills.
//
module sha256_block_hasher #(
  parameter int QDEPTH = sha_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_stall,
  input  logic [31:0] message_word,
  input  logic        first_of_message,
  input  logic        last_of_message,
  output logic        dig_valid,
  input  logic        dig_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha_pkg::*;

  // front -> queue
  logic     q_push;
  logic     q_full;
  sha_blk_t q_in;
  // queue -> back
  logic     q_pop;
  logic     q_valid;
  sha_blk_t q_head;

  // front: block position, first-word restart, block assembly
  sha_front u_front (
    .clk              (clk),
    .rst              (rst),
    .msg_valid        (msg_valid),
    .message_word     (message_word),
    .first_of_message (first_of_message),
    .last_of_message  (last_of_message),
    .msg_stall        (msg_stall),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_in)
  );

  // whole blocks wait here while the back compresses
  sha_blk_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  // back: rounds, chaining update and digest read-out
  sha_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_head),
    .q_pop       (q_pop),
    .dig_valid   (dig_valid),
    .dig_stall   (dig_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

endmodule

// File: design/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front
// Takes message words, tracks their place in the block and assembles blocks.
// ----------------------------------------------------------------------------
module sha_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              msg_valid,
  input  logic [31:0]       message_word,
  input  logic              first_of_message,
  input  logic              last_of_message,
  output logic              msg_stall,
  input  logic              q_full,
  output logic              q_push,
  output sha_pkg::sha_blk_t q_data
);
  import sha_pkg::*;

  localparam logic [3:0] LAST_POS = 4'(WORDS_PER_BLOCK - 1);

  logic [3:0]  pos;
  logic [3:0]  eff_pos;
  logic        accept;
  logic        blk_init;
  logic [31:0] asm_words [WORDS_PER_BLOCK-1];

  // a first word restarts the block; any partial block is dropped
  assign eff_pos   = first_of_message ? 4'd0 : pos;
  assign msg_stall = q_full && (pos == LAST_POS);
  assign accept    = msg_valid && !msg_stall;
  assign q_push    = accept && (eff_pos == LAST_POS);

  always_comb begin
    for (int i = 0; i < WORDS_PER_BLOCK - 1; i++) begin
      q_data.words[i] = asm_words[i];
    end
    q_data.words[WORDS_PER_BLOCK-1] = message_word;
    q_data.init = blk_init;
    q_data.last = last_of_message;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 4'd0;
    end else if (accept) begin
      pos <= eff_pos + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (eff_pos != LAST_POS)) begin
      asm_words[eff_pos] <= message_word;
    end
    if (accept && (eff_pos == 4'd0)) begin
      blk_init <= first_of_message;
    end
  end

  a_stall_only_at_end: assert property (@(posedge clk) disable iff (rst)
    msg_stall |-> (pos == LAST_POS && q_full))
    else $error("front stalled away from block end");

endmodule

// File: design/sha_blk_queue.sv
// ----------------------------------------------------------------------------
// sha_blk_queue
// Short FIFO of complete blocks between front and back.
// ----------------------------------------------------------------------------
module sha_blk_queue #(
  parameter int DEPTH = sha_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sha_pkg::sha_blk_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output sha_pkg::sha_blk_t head_data
);
  import sha_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sha_blk_t        entries [DEPTH];
  logic [PW-1:0]   head;
  logic [PW-1:0]   tail;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[head];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    bump = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= bump(tail);
      end
      if (do_pop) begin
        head <= bump(head);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[tail] <= push_data;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("block pushed into full queue");

endmodule

// File: design/sha_back.sv
// ----------------------------------------------------------------------------
// sha_back
// Compression engine: one round a cycle; a final block's digest is read out.
// ----------------------------------------------------------------------------
module sha_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  sha_pkg::sha_blk_t q_data,
  output logic              q_pop,
  output logic              dig_valid,
  input  logic              dig_stall,
  output logic [31:0]       digest_word,
  output logic [2:0]        word_index,
  output logic              last_word
);
  import sha_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_FIN   = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  localparam logic [5:0] LAST_RND = 6'(ROUNDS - 1);
  localparam logic [2:0] LAST_IDX = 3'(DIGEST_WORDS - 1);

  logic [1:0]  state;
  logic [5:0]  rnd;
  logic [2:0]  oidx;
  logic        blk_last;
  logic [31:0] cv   [DIGEST_WORDS];
  logic [31:0] wv   [DIGEST_WORDS];
  logic [31:0] win  [WORDS_PER_BLOCK];
  logic [31:0] hkw;                   // h + K[t] + W[t], formed one round early
  logic [31:0] base [DIGEST_WORDS];
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] new_w;
  logic        out_take;

  assign q_pop     = (state == ST_IDLE) && q_valid;
  assign dig_valid = (state == ST_OUT);
  assign out_take  = dig_valid && !dig_stall;

  assign digest_word = cv[oidx];
  assign word_index  = oidx;
  assign last_word   = (oidx == LAST_IDX);

  always_comb begin
    for (int i = 0; i < DIGEST_WORDS; i++) begin
      base[i] = q_data.init ? INIT_HASH[i] : cv[i];
    end
  end

  assign t1    = hkw + big_sigma1(wv[4]) + choose(wv[4], wv[5], wv[6]);
  assign t2    = big_sigma0(wv[0]) + majority(wv[0], wv[1], wv[2]);
  assign new_w = small_sigma1(win[14]) + win[9] + small_sigma0(win[1]) + win[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        cv[i] <= INIT_HASH[i];
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
              cv[i] <= base[i];
            end
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          if (rnd == LAST_RND) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          for (int i = 0; i < DIGEST_WORDS; i++) begin
            cv[i] <= cv[i] + wv[i];
          end
          state <= blk_last ? ST_OUT : ST_IDLE;
        end
        ST_OUT: begin
          if (out_take && (oidx == LAST_IDX)) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
              cv[i] <= INIT_HASH[i];
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          for (int i = 0; i < DIGEST_WORDS; i++) begin
            wv[i] <= base[i];
          end
          for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
            win[i] <= q_data.words[i];
          end
          hkw      <= base[7] + ROUND_K[0] + q_data.words[0];
          rnd      <= 6'd0;
          blk_last <= q_data.last;
        end
      end
      ST_ROUND: begin
        wv[7] <= wv[6];
        wv[6] <= wv[5];
        wv[5] <= wv[4];
        wv[4] <= wv[3] + t1;
        wv[3] <= wv[2];
        wv[2] <= wv[1];
        wv[1] <= wv[0];
        wv[0] <= t1 + t2;
        for (int i = 0; i < WORDS_PER_BLOCK - 1; i++) begin
          win[i] <= win[i+1];
        end
        win[WORDS_PER_BLOCK-1] <= new_w;
        hkw <= wv[6] + ROUND_K[6'(rnd + 6'd1)] + win[1];
        rnd <= rnd + 6'd1;
      end
      ST_FIN: begin
        oidx <= 3'd0;
      end
      ST_OUT: begin
        if (out_take) begin
          oidx <= oidx + 3'd1;
        end
      end
      default: begin
      end
    endcase
  end

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && rnd == LAST_RND) |=> (state == ST_FIN))
    else $error("compression did not finish after last round");

  a_digest_done: assert property (@(posedge clk) disable iff (rst)
    (out_take && last_word) |=> (state == ST_IDLE && !dig_valid))
    else $error("digest read-out did not close");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == ST_ROUND && rnd == 6'd0))
    else $error("block taken without starting rounds");

endmodule

// File: dv/tb_sha256_block_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha256_block_hasher
// Self-checking bench for the SHA-256 block hasher. Pre-padded messages are
// streamed in one word at a time, an in-bench SHA-256 model predicts every
// digest request, and the digest channel is checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_sha256_block_hasher;

  localparam int          HOLD_AFTER  = 120;      // words taken before the long hold
  localparam int          HOLD_CYCLES = 400;      // long digest hold, in cycles
  localparam int          DRAIN_WAIT  = 300;      // covers up to three queued blocks
  localparam int          TIMEOUT_NS  = 800_000;  // overall timeout, far above a slow run
  localparam int          NUM_WORDS   = 300;
  localparam logic [3:0]  LAST_SLOT   = 4'd15;    // sixteenth word of a block

  // FIPS 180-4 initial hash and round constants, kept here independently
  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // one message-word request, with the idle cycles the sender spends before it
  typedef struct {
    logic [31:0] word;
    logic        first;
    logic        last;
    int unsigned gap;
  } msg_req_t;

  // one digest-word request as it should appear on the output
  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_req_t;

  logic        clk              = 1'b0;
  logic        rst              = 1'b1;
  logic        msg_valid        = 1'b0;
  logic        msg_stall;
  logic [31:0] message_word     = '0;
  logic        first_of_message = 1'b0;
  logic        last_of_message  = 1'b0;
  logic        dig_valid;
  logic        dig_stall        = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  // handshake flags, set at the rising edge and used at the next falling edge
  logic        msg_hit          = 1'b0;
  logic        dig_hit          = 1'b0;
  logic        hold_digests     = 1'b0;

  msg_req_t    pending_words[$];
  digest_req_t digest_due[$];

  // predictor state: chaining value, current block words, fill position
  logic [31:0] chain [8];
  logic [31:0] sched [16];
  logic [3:0]  fill             = '0;

  int          words_taken      = 0;
  int          errors           = 0;
  int unsigned idle_cnt         = 0;
  int unsigned stall_left       = 0;
  bit          tx_calm          = 1'b0;
  bit          rx_calm          = 1'b0;

  sha256_block_hasher DUT (
    .clk              (clk),
    .rst              (rst),
    .msg_valid        (msg_valid),
    .msg_stall        (msg_stall),
    .message_word     (message_word),
    .first_of_message (first_of_message),
    .last_of_message  (last_of_message),
    .dig_valid        (dig_valid),
    .dig_stall        (dig_stall),
    .digest_word      (digest_word),
    .word_index       (word_index),
    .last_word        (last_word)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic logic [31:0] ror32(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // One compression over the sixteen stored words. The schedule is expanded
  // in full here rather than kept in a rolling window.
  function automatic void run_rounds();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    int t;
    for (t = 0; t < 16; t++) w[t] = sched[t];
    for (t = 16; t < 64; t++) begin
      s0   = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1   = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                chain[4], chain[5], chain[6], chain[7]};
    for (t = 0; t < 64; t++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_CONST[t] + w[t];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g;
      g = f;
      f = e;
      e = d + t1;
      d = c;
      c = b;
      b = a;
      a = t1 + t2;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
    chain[5] += f;
    chain[6] += g;
    chain[7] += h;
  endfunction

  // Takes one accepted message word. A first flag restarts from the IV and
  // drops any partial block; a last flag only counts on a block's sixteenth
  // word. After a digest the chaining value goes back to the IV.
  function automatic void absorb_word(logic [31:0] word, logic first, logic last);
    logic [3:0] pos;
    int i;
    if (first) begin
      chain = HASH_IV;
      fill  = '0;
    end
    pos        = fill;
    sched[pos] = word;
    fill       = pos + 4'd1;
    if (pos == LAST_SLOT) begin
      run_rounds();
      if (last) begin
        for (i = 0; i < 8; i++)
          digest_due.push_back('{word: chain[i], index: 3'(i), last: (i == 7)});
        chain = HASH_IV;
      end
    end
  endfunction

  function automatic void log_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Queues one message word; the sender drifts in and out of a no-gap mode
  // so that long back-to-back runs show up among the random gaps.
  function automatic void add_word(logic [31:0] word, logic first, logic last);
    if ($urandom_range(0, 19) == 0) tx_calm = !tx_calm;
    pending_words.push_back('{word: word, first: first, last: last,
                              gap: tx_calm ? 0 : $urandom_range(0, 6)});
  endfunction

  // mostly random words, with all-zero and all-one words mixed in
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: message channel, driven on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      msg_valid <= 1'b0;
    end else if (msg_valid && !msg_hit) begin
      // still stalled: hold the request as it is
    end else if (pending_words.size() != 0 && idle_cnt >= pending_words[0].gap) begin
      msg_valid        <= 1'b1;
      message_word     <= pending_words[0].word;
      first_of_message <= pending_words[0].first;
      last_of_message  <= pending_words[0].last;
      void'(pending_words.pop_front());
      idle_cnt         <= 0;
    end else begin
      msg_valid <= 1'b0;
      idle_cnt  <= idle_cnt + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: both handshakes sampled on the rising edge. Message requests
  // feed the predictor first, then any digest request is checked, so the
  // outcome never hangs on process order.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    digest_req_t want;
    msg_hit <= !rst && msg_valid && !msg_stall;
    dig_hit <= !rst && dig_valid && !dig_stall;
    if (!rst && msg_valid && !msg_stall) begin
      absorb_word(message_word, first_of_message, last_of_message);
      words_taken <= words_taken + 1;
    end
    if (!rst && dig_valid && !dig_stall) begin
      if (digest_due.size() == 0) begin
        log_error($sformatf("unexpected digest request: word %h index %0d last %b",
                            digest_word, word_index, last_word));
      end else begin
        want = digest_due.pop_front();
        if (digest_word !== want.word || word_index !== want.index ||
            last_word !== want.last)
          log_error($sformatf("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                              want.word, want.index, want.last,
                              digest_word, word_index, last_word));
      end
    end
  end

  // Receiver: after each digest request draw a random stall length, or none in
  // calm stretches; the long hold overrides everything.
  always @(negedge clk) begin
    if (rst) begin
      dig_stall <= 1'b0;
    end else begin
      if (dig_hit) begin
        if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
        stall_left = rx_calm ? 0 : $urandom_range(0, 6);
      end
      dig_stall <= hold_digests || stall_left != 0;
      if (stall_left != 0) stall_left = stall_left - 1;
    end
  end

  // Long digest hold part-way through: the back end stops, the block queue
  // fills, and the front has to stall the sender.
  initial begin
    while (words_taken < HOLD_AFTER) @(posedge clk);
    hold_digests <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_digests <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of test
  // --------------------------------------------------------------------------
  initial begin
    int blocks, b, j, n;
    bit open;

    chain = HASH_IV;

    // partial message of extreme words, dropped by the next first flag;
    // its early last flag must be ignored
    add_word(32'hffff_ffff, 1'b1, 1'b0);
    add_word(32'h0000_0000, 1'b0, 1'b1);

    // "abc" padded to one block, with a stray last flag on word 2
    for (j = 0; j < 16; j++)
      add_word(j == 0 ? 32'h6162_6380 : (j == 15 ? 32'h0000_0018 : 32'h0),
               j == 0, j == 2 || j == 15);

    // straight after a digest, a message with no first flag must still
    // start from the IV
    for (j = 0; j < 16; j++)
      add_word(32'hffff_ffff, 1'b0, j == 15);

    // Random messages: mostly well-formed one- to three-block messages,
    // some without a first flag, some with stray last flags, and now and
    // then a broken fragment that the next message cuts short or absorbs.
    while (pending_words.size() < NUM_WORDS) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 15);
        for (j = 0; j < n; j++)
          add_word(pick_word(), j == 0 && $urandom_range(0, 1) == 1,
                   $urandom_range(0, 3) == 0);
      end
      blocks = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
      open   = $urandom_range(0, 7) != 0;
      for (b = 0; b < blocks; b++)
        for (j = 0; j < 16; j++)
          add_word(pick_word(), open && b == 0 && j == 0,
                   (b == blocks - 1 && j == 15) ||
                   (j != 15 && $urandom_range(0, 15) == 0));
    end
    // close with a clean message so the tail ends on a digest
    for (j = 0; j < 16; j++)
      add_word(pick_word(), j == 0, j == 15);

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || msg_valid) @(posedge clk);
    while (digest_due.size() != 0) @(posedge clk);
    // let any block still in the engine finish; stray requests get flagged
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0 && digest_due.size() == 0) begin
      $display("tb_sha256_block_hasher: done, clean");
    end else begin
      $display("tb_sha256_block_hasher: done, errors");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_sha256_block_hasher: done, errors");
    $finish;
  end

endmodule

// File: sha256_block_hasher.f
design/sha_pkg.sv
design/sha_front.sv
design/sha_blk_queue.sv
design/sha_back.sv
design/sha256_block_hasher.sv
dv/tb_sha256_block_hasher.sv
